// ===== sv/cdsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsp_pkg
// Shared widths, constants and controller/datapath interface types for the
// call distance shortest path block.
// ----------------------------------------------------------------------------
package cdsp_pkg;

  // Fixed field widths
  localparam int NODE_W = 6;   // node index width
  localparam int DIST_W = 7;   // distance width
  localparam int EDGE_W = 7;   // edge entry: valid bit above index

  // Distance saturation value
  localparam logic [DIST_W-1:0] DIST_SAT = 7'd127;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // input transaction accepted, store node
    logic init;      // seed entry node
    logic take;      // clear pending mark at ptr, read node and edges
    logic node_lat;  // latch source distance, read first successor
    logic e1_upd;    // relax first edge
    logic e2_rd;     // read second successor
    logic e2_upd;    // relax the other edge
    logic out_rd;    // read node at ptr for output
    logic out_ld;    // load output register
    logic clear;     // drop marks and node count
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ptr_end;   // ptr equals node count
    logic ptr_last;  // ptr is the final loaded node
    logic pend_hit;  // node at ptr is pending
    logic out_busy;  // output register full and stalled
  } sts_t;

endpackage

// ===== sv/cdsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdsp_ctrl
// Sequencer: node load, relaxation passes over pending nodes, result readout.
// ----------------------------------------------------------------------------
module cdsp_ctrl #(
  parameter int MAX_NODES = 64,
  localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_node,
  output logic              in_stall,
  input  cdsp_pkg::sts_t    sts,
  output cdsp_pkg::cmd_t    cmd,
  output logic [CNT_W-1:0]  ptr
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_NODE = 4'd3;
  localparam logic [3:0] S_E1   = 4'd4;
  localparam logic [3:0] S_E2RD = 4'd5;
  localparam logic [3:0] S_E2   = 4'd6;
  localparam logic [3:0] S_ORD  = 4'd7;
  localparam logic [3:0] S_OWR  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             any_r, any_nxt;   // pass processed a pending node

  assign ptr      = ptr_r;
  assign in_stall = (state_r != S_LOAD);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    any_nxt   = any_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && in_last_node) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        ptr_nxt   = '0;
        any_nxt   = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.ptr_end) begin
          ptr_nxt = '0;
          any_nxt = 1'b0;
          if (!any_r) begin
            state_nxt = S_ORD;
          end
        end else if (sts.pend_hit) begin
          cmd.take  = 1'b1;
          any_nxt   = 1'b1;
          state_nxt = S_NODE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_NODE: begin
        cmd.node_lat = 1'b1;
        state_nxt    = S_E1;
      end
      S_E1: begin
        cmd.e1_upd = 1'b1;
        state_nxt  = S_E2RD;
      end
      S_E2RD: begin
        cmd.e2_rd = 1'b1;
        state_nxt = S_E2;
      end
      S_E2: begin
        cmd.e2_upd = 1'b1;
        ptr_nxt    = ptr_r + 1'b1;
        state_nxt  = S_SCAN;
      end
      S_ORD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OWR;
      end
      S_OWR: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          if (sts.ptr_last) begin
            cmd.clear = 1'b1;
            ptr_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ptr_r   <= '0;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      any_r   <= any_nxt;
    end
  end

endmodule

// ===== sv/cdsp_dpath.sv =====
// ----------------------------------------------------------------------------
// cdsp_dpath
// Node and edge memories, reached/pending marks, edge relaxation and the
// output register.
// ----------------------------------------------------------------------------
module cdsp_dpath #(
  parameter int MAX_NODES = 64,
  localparam int IDX_W = $clog2(MAX_NODES),
  localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdsp_pkg::cmd_t                cmd,
  output cdsp_pkg::sts_t                sts,
  input  logic [CNT_W-1:0]              ptr,
  input  logic                          in_is_call,
  input  logic                          in_first_valid,
  input  logic [cdsp_pkg::NODE_W-1:0]   in_first_next,
  input  logic                          in_second_valid,
  input  logic [cdsp_pkg::NODE_W-1:0]   in_second_next,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdsp_pkg::NODE_W-1:0]   out_node_index,
  output logic [cdsp_pkg::DIST_W-1:0]   out_distance,
  output logic                          out_last_result
);

  localparam int NW  = cdsp_pkg::NODE_W;
  localparam int DW  = cdsp_pkg::DIST_W;
  localparam int EW  = cdsp_pkg::EDGE_W;
  localparam int CMPW = NW + 1;

  // Memories: edge pair per node, {call, distance} per node
  logic [2*EW-1:0] edge_mem [MAX_NODES];
  logic [DW:0]     node_mem [MAX_NODES];

  logic [CNT_W-1:0]     count_r;
  logic                 call0_r;
  logic [MAX_NODES-1:0] reached_r;
  logic [MAX_NODES-1:0] pending_r;
  logic [2*EW-1:0]      edge_rd_r;
  logic [DW:0]          node_rd_r;
  logic [DW-1:0]        dist_i_r;
  logic                 out_valid_r;
  logic [NW-1:0]        out_idx_r;
  logic [DW-1:0]        out_dist_r;
  logic                 out_last_r;

  logic [IDX_W-1:0] ptr_idx;
  logic [EW-1:0]    edge1, edge2, cur_edge;
  logic [NW-1:0]    cur_to;
  logic [IDX_W-1:0] to_idx;
  logic             to_ok;
  logic             cur_call;
  logic [DW-1:0]    cur_dist;
  logic [DW-1:0]    cand;
  logic             upd;
  logic             store;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DW:0]      wr_data;
  logic [2*EW-1:0]  edge_wr;

  assign ptr_idx = ptr[IDX_W-1:0];
  assign edge1   = edge_rd_r[2*EW-1:EW];
  assign edge2   = edge_rd_r[EW-1:0];

  // Edge under relaxation and candidate distance
  assign cur_edge = cmd.e2_upd ? edge2 : edge1;
  assign cur_to   = cur_edge[NW-1:0];
  assign to_idx   = cur_to[IDX_W-1:0];
  assign to_ok    = cur_edge[EW-1] && (CMPW'(cur_to) < CMPW'(count_r));
  assign cur_call = node_rd_r[DW];
  assign cur_dist = node_rd_r[DW-1:0];
  assign cand     = (dist_i_r == cdsp_pkg::DIST_SAT) ? cdsp_pkg::DIST_SAT
                                                     : dist_i_r + DW'(cur_call);
  assign upd      = (cmd.e1_upd || cmd.e2_upd) && to_ok &&
                    (!reached_r[to_idx] || (cur_dist > cand));

  // Store only while there is room
  assign store = cmd.load && (count_r < CNT_W'(MAX_NODES));

  // Edge entry for an incoming node; the other edge needs the first
  assign edge_wr = {(in_first_valid ? {1'b1, in_first_next} : {EW{1'b0}}),
                    ((in_first_valid && in_second_valid) ? {1'b1, in_second_next}
                                                         : {EW{1'b0}})};

  // Node memory read address
  always_comb begin
    rd_en   = cmd.take || cmd.node_lat || cmd.e2_rd || cmd.out_rd;
    rd_addr = ptr_idx;
    if (cmd.node_lat) begin
      rd_addr = edge1[IDX_W-1:0];
    end else if (cmd.e2_rd) begin
      rd_addr = edge2[IDX_W-1:0];
    end
  end

  // Node memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = {in_is_call, {DW{1'b0}}};
    if (store) begin
      wr_en = 1'b1;
    end else if (cmd.init) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {call0_r, DW'(call0_r)};
    end else if (upd) begin
      wr_en   = 1'b1;
      wr_addr = to_idx;
      wr_data = {cur_call, cand};
    end
  end

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (store) begin
      edge_mem[count_r[IDX_W-1:0]] <= edge_wr;
    end
    if (cmd.take) begin
      edge_rd_r <= edge_mem[ptr_idx];
    end
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      node_rd_r <= node_mem[rd_addr];
    end
  end

  // Source distance of the node being expanded
  always_ff @(posedge clk) begin
    if (cmd.node_lat) begin
      dist_i_r <= node_rd_r[DW-1:0];
    end
    if (store && (count_r == '0)) begin
      call0_r <= in_is_call;
    end
  end

  // Node count and marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      reached_r <= '0;
      pending_r <= '0;
    end else if (cmd.clear) begin
      count_r   <= '0;
      reached_r <= '0;
      pending_r <= '0;
    end else begin
      if (store) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.init) begin
        reached_r[0] <= 1'b1;
        pending_r[0] <= 1'b1;
      end
      if (cmd.take) begin
        pending_r[ptr_idx] <= 1'b0;
      end
      if (upd) begin
        reached_r[to_idx] <= 1'b1;
        pending_r[to_idx] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_idx_r  <= NW'(ptr);
      out_dist_r <= reached_r[ptr_idx] ? node_rd_r[DW-1:0] : {DW{1'b0}};
      out_last_r <= sts.ptr_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_idx_r;
  assign out_distance    = out_dist_r;
  assign out_last_result = out_last_r;

  // Status
  assign sts.ptr_end  = (CMPW'(ptr) == CMPW'(count_r));
  assign sts.ptr_last = (CMPW'(ptr) + 1'b1 == CMPW'(count_r));
  assign sts.pend_hit = pending_r[ptr_idx];
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// ===== sv/call_distance_shortest_path.sv =====
// ----------------------------------------------------------------------------
// call_distance_shortest_path
// Fewest call nodes on any path from the entry of a loaded control-flow graph.
// ----------------------------------------------------------------------------
// Nodes load one per cycle, in index order, node 0 first. After the node
// marked last the input stalls while the search runs: passes sweep the node
// list, passing over idle nodes and expanding each pending node (a single
// node memory read port: read then update for each of its edges),
// repeating until a pass finds nothing pending, so search time depends on
// the graph. Results then leave in index order, one at a time (node memory
// read, then the output register), held back by any output stall. Input is
// taken again as soon as the final result sits in the output register.
module call_distance_shortest_path #(
  parameter int MAX_NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_is_call,
  input  logic                          in_first_valid,
  input  logic [cdsp_pkg::NODE_W-1:0]   in_first_next,
  input  logic                          in_second_valid,
  input  logic [cdsp_pkg::NODE_W-1:0]   in_second_next,
  input  logic                          in_last_node,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdsp_pkg::NODE_W-1:0]   out_node_index,
  output logic [cdsp_pkg::DIST_W-1:0]   out_distance,
  output logic                          out_last_result
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);

  cdsp_pkg::cmd_t   cmd;
  cdsp_pkg::sts_t   sts;
  logic [CNT_W-1:0] ptr;

  // Controller
  cdsp_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd),
    .ptr          (ptr)
  );

  // Datapath
  cdsp_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .ptr             (ptr),
    .in_is_call      (in_is_call),
    .in_first_valid  (in_first_valid),
    .in_first_next   (in_first_next),
    .in_second_valid (in_second_valid),
    .in_second_next  (in_second_next),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_index  (out_node_index),
    .out_distance    (out_distance),
    .out_last_result (out_last_result)
  );

endmodule

// ===== sv/cdsp_checker.sv =====
// ----------------------------------------------------------------------------
// cdsp_checker
// Port-level checks on result ordering, distance range and input stalling.
// ----------------------------------------------------------------------------
module cdsp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_last_node,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cdsp_pkg::NODE_W-1:0]   out_node_index,
  input logic [cdsp_pkg::DIST_W-1:0]   out_distance,
  input logic                          out_last_result
);

  logic                        out_acc;
  logic                        open_r;   // a result list is partly delivered
  logic [cdsp_pkg::NODE_W-1:0] prev_idx_r;

  assign out_acc = out_valid && !out_stall;

  // Track the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      prev_idx_r <= '0;
    end else if (out_acc) begin
      open_r     <= !out_last_result;
      prev_idx_r <= out_node_index;
    end
  end

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node_index) &&
    $stable(out_distance) && $stable(out_last_result))
    else $error("stalled result changed");

  // Results step through node indexes
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && open_r |-> out_node_index == prev_idx_r + 1'b1)
    else $error("result index out of sequence");

  // Each result list starts at the entry node
  a_idx_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !open_r |-> out_node_index == '0)
    else $error("result list does not start at node 0");

  // A distance never exceeds the maximum node count of 64
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= 7'd64)
    else $error("distance out of range");

  // No input during search or while a result list is being delivered
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) || (in_valid && !in_stall && in_last_node)
    |=> in_stall || (out_valid && out_last_result))
    else $error("input taken during search or readout");

endmodule

bind call_distance_shortest_path cdsp_checker u_cdsp_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for call_distance_shortest_path: small control-flow
// graphs are loaded node by node with random idle gaps on both channels, the
// fewest-call distances are predicted on the side and every reported node is
// compared field by field against the prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          NODE_W      = cdsp_pkg::NODE_W;
  localparam int          DIST_W      = cdsp_pkg::DIST_W;
  localparam int          MAX_NODES   = 64;
  localparam int unsigned NODE_TARGET = 210;      // stop opening new graphs here
  localparam int unsigned DRAIN       = 200;      // quiet cycles after last result
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned REPORT_MAX  = 10;

  // One node of the graph as presented on the input channel
  typedef struct packed {
    logic              is_call;
    logic              first_valid;
    logic [NODE_W-1:0] first_next;
    logic              second_valid;
    logic [NODE_W-1:0] second_next;
    logic              last_node;
  } node_item_t;

  // One reported node distance
  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [DIST_W-1:0] distance;
    logic              last_result;
  } dist_item_t;

  // --------------------------------------------------------------------------
  // Distance scoreboard: keeps the graph being loaded, solves it when the
  // final node arrives and holds the per-node distances still to be seen.
  // --------------------------------------------------------------------------
  class distance_tracker;
    node_item_t  stored_nodes[$];
    dist_item_t  expected_results[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= REPORT_MAX)
        $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // Accepted input transaction: store it, and on the final node run the
    // 0-1 weight relaxation until nothing improves
    function void take_node(node_item_t nd);
      int unsigned count;
      int          cost[MAX_NODES];
      bit          reached[MAX_NODES];
      bit          changed;
      bit          hop_ok;
      int unsigned hop;
      int          cand;
      dist_item_t  res;
      // nodes past the memory size are dropped
      if (stored_nodes.size() < MAX_NODES)
        stored_nodes.push_back(nd);
      if (!nd.last_node)
        return;
      count = stored_nodes.size();
      for (int i = 0; i < MAX_NODES; i++) begin
        cost[i]    = 0;
        reached[i] = 1'b0;
      end
      // entry counts itself when it is a call
      cost[0]    = stored_nodes[0].is_call ? 1 : 0;
      reached[0] = 1'b1;
      changed    = 1'b1;
      while (changed) begin
        changed = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
          if (reached[i]) begin
            for (int e = 0; e < 2; e++) begin
              // the other edge only counts behind a valid first edge
              hop_ok = (e == 0) ? stored_nodes[i].first_valid
                                : (stored_nodes[i].first_valid && stored_nodes[i].second_valid);
              hop    = (e == 0) ? stored_nodes[i].first_next : stored_nodes[i].second_next;
              // edges into nodes that were never loaded are ignored
              if (hop_ok && hop < count) begin
                cand = cost[i] + (stored_nodes[hop].is_call ? 1 : 0);
                if (cand > int'(cdsp_pkg::DIST_SAT))
                  cand = int'(cdsp_pkg::DIST_SAT);
                if (!reached[hop] || cost[hop] > cand) begin
                  cost[hop]    = cand;
                  reached[hop] = 1'b1;
                  changed      = 1'b1;
                end
              end
            end
          end
        end
      end
      // one result per stored node, unreachable nodes report zero
      for (int unsigned i = 0; i < count; i++) begin
        res.node_index  = i[NODE_W-1:0];
        res.distance    = reached[i] ? cost[i][DIST_W-1:0] : '0;
        res.last_result = (i + 1 == count);
        expected_results.push_back(res);
      end
      stored_nodes.delete();
    endfunction

    // Accepted result transaction against the oldest expectation
    function void check_distance(dist_item_t got);
      dist_item_t want;
      if (expected_results.size() == 0) begin
        log_failure($sformatf("unexpected result: node %0d distance %0d last %0b",
                              got.node_index, got.distance, got.last_result));
        return;
      end
      want = expected_results.pop_front();
      if (got.node_index !== want.node_index || got.distance !== want.distance ||
          got.last_result !== want.last_result)
        log_failure($sformatf({"result mismatch: expected node %0d distance %0d last %0b,",
                               " got node %0d distance %0d last %0b"},
                              want.node_index, want.distance, want.last_result,
                              got.node_index, got.distance, got.last_result));
    endfunction

    function void flag_leftovers();
      while (expected_results.size() > 0) begin
        log_failure($sformatf("missing result: node %0d distance %0d",
                              expected_results[0].node_index,
                              expected_results[0].distance));
        void'(expected_results.pop_front());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_is_call;
  logic              in_first_valid;
  logic [NODE_W-1:0] in_first_next;
  logic              in_second_valid;
  logic [NODE_W-1:0] in_second_next;
  logic              in_last_node;
  logic              out_valid;
  logic              out_stall;
  logic [NODE_W-1:0] out_node_index;
  logic [DIST_W-1:0] out_distance;
  logic              out_last_result;

  distance_tracker tracker = new();
  int unsigned     nodes_sent = 0;
  int unsigned     cycle_count = 0;
  bit              out_quiet = 1'b0;

  call_distance_shortest_path #(
    .MAX_NODES(MAX_NODES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_is_call     (in_is_call),
    .in_first_valid (in_first_valid),
    .in_first_next  (in_first_next),
    .in_second_valid(in_second_valid),
    .in_second_next (in_second_next),
    .in_last_node   (in_last_node),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_node_index (out_node_index),
    .out_distance   (out_distance),
    .out_last_result(out_last_result)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("call_distance_shortest_path test failed");
      $finish;
    end
  end

  // Result monitor: sample on the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_distance('{out_node_index, out_distance, out_last_result});
  end

  // Result side back-pressure: random stall before each transaction
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      hold = out_quiet ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1)
        @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  // Offer one node after a random gap; return right after its acceptance edge
  task automatic send_node(input bit call, input bit fv, input logic [NODE_W-1:0] fn,
                           input bit sv, input logic [NODE_W-1:0] sn, input bit last,
                           input bit hurry);
    int unsigned gap;
    gap = hurry ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_is_call      <= call;
    in_first_valid  <= fv;
    in_first_next   <= fn;
    in_second_valid <= sv;
    in_second_next  <= sn;
    in_last_node    <= last;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    tracker.take_node('{call, fv, fn, sv, sn, last});
    nodes_sent++;
  endtask

  // Mostly well-formed graph with random shape; some nodes are pure noise
  task automatic send_random_graph(input int unsigned size);
    int unsigned        span;
    bit                 hurry;
    bit                 noise;
    bit                 call, fv, sv;
    logic [NODE_W-1:0]  fn, sn;
    hurry     = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    span      = (size > MAX_NODES) ? MAX_NODES : size;
    for (int unsigned k = 0; k < size; k++) begin
      noise = ($urandom_range(0, 7) == 0);
      call  = ($urandom_range(0, 9) < 4);
      fv    = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 6) != 0);
      sv    = 1'($urandom_range(0, 1));
      fn    = (noise || $urandom_range(0, 4) == 0) ? NODE_W'($urandom_range(0, 63))
                                                   : NODE_W'($urandom_range(0, span - 1));
      sn    = (noise || $urandom_range(0, 4) == 0) ? NODE_W'($urandom_range(0, 63))
                                                   : NODE_W'($urandom_range(0, span - 1));
      send_node(call, fv, fn, sv, sn, k + 1 == size, hurry);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gsize;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_is_call      <= 1'b0;
    in_first_valid  <= 1'b0;
    in_first_next   <= '0;
    in_second_valid <= 1'b0;
    in_second_next  <= '0;
    in_last_node    <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single call node looping on itself through both edges
    send_node(1, 1, 0, 1, 0, 1, 0);
    // single plain node, other edge set without a first one
    send_node(0, 0, 0, 1, 0, 1, 1);

    // branches, edges past the loaded nodes, an edge dropped behind an invalid first one,
    // an unreachable node and an unreachable tail
    send_node(0, 1, 1, 1, 2, 0, 0);
    send_node(1, 1, 3, 0, 63, 0, 0);
    send_node(0, 1, 3, 1, 63, 0, 0);
    send_node(1, 0, 0, 1, 5, 0, 0);
    send_node(1, 1, 0, 0, 0, 0, 0);
    send_node(0, 1, 62, 1, 5, 1, 0);

    // all calls, top index values, back edge to the entry
    out_quiet = 1'b1;
    send_node(1, 1, 1, 1, 63, 0, 1);
    send_node(1, 1, 63, 1, 2, 0, 1);
    send_node(1, 1, 3, 1, 0, 0, 1);
    send_node(1, 1, 63, 1, 63, 1, 1);

    // a shorter path that is found late
    out_quiet = 1'b0;
    send_node(0, 1, 1, 1, 2, 0, 0);
    send_node(1, 1, 3, 0, 0, 0, 0);
    send_node(1, 1, 4, 0, 0, 0, 0);
    send_node(1, 1, 4, 1, 1, 0, 0);
    send_node(0, 0, 0, 0, 0, 1, 0);

    // more nodes than the memory holds, then random graphs up to the target
    send_random_graph(MAX_NODES + $urandom_range(1, 3));
    while (nodes_sent < NODE_TARGET) begin
      gsize = ($urandom_range(0, 9) == 0) ? MAX_NODES : $urandom_range(2, 12);
      if (gsize > NODE_TARGET - nodes_sent)
        gsize = NODE_TARGET - nodes_sent;
      send_random_graph(gsize);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    out_quiet = 1'b0;

    // drain and watch for stray results
    while (tracker.outstanding() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    tracker.flag_leftovers();

    if (tracker.failures == 0)
      $display("call_distance_shortest_path test passed");
    else
      $display("call_distance_shortest_path test failed");
    $finish;
  end

endmodule
